// ===== sv/pdst_pkg.sv =====
// ----------------------------------------------------------------------------
// pdst_pkg: shared types and constants of the polled delay slot table
// Table geometry, entry layout and the request/update records passed
// between the sequencer, the slot store and the update unit.
// ----------------------------------------------------------------------------
`default_nettype none

package pdst_pkg;

  localparam int SLOT_COUNT = 256;
  localparam int SLOT_AW    = $clog2(SLOT_COUNT);
  localparam int SLOT_W     = 8;
  localparam int COUNT_W    = 16;

  // One table entry: armed mark and countdown value
  typedef struct packed {
    logic               armed;
    logic [COUNT_W-1:0] remaining;
  } entry_t;

  // Captured item, decoded for the update unit
  typedef struct packed {
    logic               clear;
    logic               in_range;
    logic               slot_zero;
    logic [COUNT_W-1:0] count;
  } req_t;

  // Update unit status toward the sequencer
  typedef struct packed {
    logic wr_en;
    logic fired;
  } upd_t;

  function automatic logic [SLOT_AW-1:0] slot_index(input logic [SLOT_W-1:0] s);
    logic [31:0] wide;
    wide = 32'(s);
    return wide[SLOT_AW-1:0];
  endfunction

  function automatic logic slot_in_range(input logic [SLOT_W-1:0] s);
    return 32'(s) < 32'(SLOT_COUNT);
  endfunction

endpackage

`default_nettype wire

// ===== sv/pdst_mem.sv =====
// ----------------------------------------------------------------------------
// pdst_mem: slot table storage
// One write port, one registered read port. A per-entry valid bit, cleared
// at reset, makes entries never written since reset read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module pdst_mem
  import pdst_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               rd_en,
  input  wire logic [SLOT_AW-1:0] rd_addr,
  output entry_t                  rd_data,
  input  wire logic               wr_en,
  input  wire logic [SLOT_AW-1:0] wr_addr,
  input  wire entry_t             wr_data
);

  entry_t                  ram [SLOT_COUNT];
  logic [SLOT_COUNT-1:0]   vld;
  entry_t                  rd_raw;
  logic                    rd_vld;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      ram[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_raw <= ram[rd_addr];
      rd_vld <= vld[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (wr_en) begin
      vld[wr_addr] <= 1'b1;
    end
  end

  assign rd_data = rd_vld ? rd_raw : '0;

endmodule

`default_nettype wire

// ===== sv/pdst_upd.sv =====
// ----------------------------------------------------------------------------
// pdst_upd: slot update unit
// Clear, arm or decrement-and-compare unit that turns the fetched entry and
// the current item into the write-back entry and the expired flag.
// ----------------------------------------------------------------------------
`default_nettype none

module pdst_upd
  import pdst_pkg::*;
(
  input  wire req_t   req,
  input  wire entry_t cur,
  output entry_t      nxt,
  output upd_t        upd
);

  logic               armed;
  logic               at_zero;
  logic [COUNT_W-1:0] dec;

  assign armed   = req.slot_zero | cur.armed;
  assign at_zero = (cur.remaining == '0);
  assign dec     = cur.remaining - COUNT_W'(1);

  always_comb begin
    nxt       = cur;
    upd.wr_en = 1'b0;
    upd.fired = 1'b0;
    if (req.in_range) begin
      upd.wr_en = 1'b1;
      if (req.clear) begin
        nxt = '0;
      end else if (!armed) begin
        nxt.armed     = 1'b1;
        nxt.remaining = req.count;
      end else begin
        // wrap to all ones on firing
        nxt.remaining = dec;
        if (at_zero) begin
          nxt.armed = 1'b0;
          upd.fired = 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sv/polled_delay_slot_table_core.sv =====
// ----------------------------------------------------------------------------
// polled_delay_slot_table_core: polled countdown delay slot table
// Sequencer around the slot store and the shared update unit.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries mode, slot and cycle_count.
//   mode 0 polls the slot: an idle slot is armed with cycle_count, an armed
//   slot counts down, and an armed slot at zero disarms and reports expired.
//   Slot 0 always behaves as armed. mode 1 clears the slot. Slots at or
//   beyond the table size change nothing and report 0.
//   Output channel (out_valid / out_stall) carries one expired bit per item.
//   For each item the transfer edge issues the table read; the write-back
//   edge, taken once the output register is free, writes the entry back
//   and loads the output register. in_stall stays high from transfer to
//   write-back, so a new item is taken only after the last is written back.
//   The output register lets one new item be taken while a result waits;
//   if the receiver still stalls when that item finishes, the block holds
//   it and keeps in_stall high until the output register frees.
//   Synchronous reset clears the sequencer, the output valid and every
//   entry (through per-slot valid bits), with no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module polled_delay_slot_table_core
  import pdst_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic               mode,
  input  wire logic [SLOT_W-1:0]  slot,
  input  wire logic [COUNT_W-1:0] cycle_count,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    expired
);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t             state;
  state_t             state_next;
  req_t               req;
  logic [SLOT_AW-1:0] idx;
  logic               in_xfer;
  logic               out_free;
  logic               wb;
  entry_t             cur;
  entry_t             nxt;
  upd_t               upd;
  logic               mem_wr;

  assign in_stall = (state != S_IDLE);
  assign in_xfer  = in_valid && !in_stall;
  assign out_free = !out_valid || !out_stall;
  assign wb       = (state == S_EXEC) && out_free;
  assign mem_wr   = wb && upd.wr_en;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (in_xfer) state_next = S_EXEC;
      S_EXEC: if (out_free) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // capture the item at transfer
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      req.clear     <= mode;
      req.in_range  <= slot_in_range(slot);
      req.slot_zero <= (slot == '0);
      req.count     <= cycle_count;
      idx           <= slot_index(slot);
    end
  end

  pdst_mem u_mem (
    .clk     (clk),
    .rst     (rst),
    .rd_en   (in_xfer),
    .rd_addr (slot_index(slot)),
    .rd_data (cur),
    .wr_en   (mem_wr),
    .wr_addr (idx),
    .wr_data (nxt)
  );

  pdst_upd u_upd (
    .req (req),
    .cur (cur),
    .nxt (nxt),
    .upd (upd)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (wb) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wb) begin
      expired <= upd.fired;
    end
  end

`ifndef SYNTH
  a_xfer_to_exec: assert property (@(posedge clk) disable iff (rst)
    in_xfer |=> (state == S_EXEC))
    else $error("transfer did not start execution");

  a_wb_loads_out: assert property (@(posedge clk) disable iff (rst)
    wb |=> (out_valid && state == S_IDLE))
    else $error("write-back did not load result");

  a_wr_only_exec: assert property (@(posedge clk) disable iff (rst)
    mem_wr |-> (state == S_EXEC && out_free))
    else $error("table written outside write-back");

  a_fire_is_poll: assert property (@(posedge clk) disable iff (rst)
    (wb && upd.fired) |-> (!req.clear && req.in_range))
    else $error("expired raised by clear or out-of-range item");
`endif

endmodule

`default_nettype wire

// ===== tb/polled_delay_slot_table_core_tb.sv =====
// ----------------------------------------------------------------------------
// polled_delay_slot_table_core_tb: self-checking bench for the delay slot table
// Drives poll and clear transfers through the valid/stall input channel,
// mirrors the slot table in a scoreboard and compares every expired bit
// taken from the output channel, under random gaps on both sides, then with none.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module polled_delay_slot_table_core_tb;
  import pdst_pkg::*;

  typedef enum bit {
    MODE_POLL  = 1'b0,
    MODE_CLEAR = 1'b1
  } slot_op_e;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int TAIL_CYCLES    = 8;
  localparam int ITEMS_PER_PHASE = 160;

  // Scoreboard: keeps its own copy of the slot table and predicts expired.
  class slot_table_scoreboard;
    bit                armed_mark [SLOT_COUNT];
    bit [COUNT_W-1:0]  countdown  [SLOT_COUNT];
    bit                expected_expired[$];
    int                errors;
    int                n_polls;
    int                n_clears;
    int                n_results;
    int                n_fired;

    function new();
      for (int i = 0; i < SLOT_COUNT; i++) begin
        armed_mark[i] = 1'b0;
        countdown[i]  = '0;
      end
      errors    = 0;
      n_polls   = 0;
      n_clears  = 0;
      n_results = 0;
      n_fired   = 0;
    endfunction

    function bit predict_expired(slot_op_e op, bit [SLOT_W-1:0] s, bit [COUNT_W-1:0] c);
      int               idx;
      bit               fired;
      bit [COUNT_W-1:0] cur;
      idx   = int'(s);
      fired = 1'b0;
      if (idx < SLOT_COUNT) begin
        if (op == MODE_CLEAR) begin
          armed_mark[idx] = 1'b0;
          countdown[idx]  = '0;
        end else if (idx != 0 && !armed_mark[idx]) begin
          armed_mark[idx] = 1'b1;
          countdown[idx]  = c;
        end else begin
          // counter wraps to all ones on firing
          cur            = countdown[idx];
          countdown[idx] = cur - 1'b1;
          if (cur == '0) begin
            armed_mark[idx] = 1'b0;
            fired           = 1'b1;
          end
        end
      end
      return fired;
    endfunction

    function void note_item(slot_op_e op, bit [SLOT_W-1:0] s, bit [COUNT_W-1:0] c);
      bit e;
      e = predict_expired(op, s, c);
      if (op == MODE_CLEAR) n_clears++;
      else n_polls++;
      if (e) n_fired++;
      expected_expired.push_back(e);
    endfunction

    task report(string msg);
      $display("MISMATCH @%0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_expired(bit got);
      bit want;
      n_results++;
      if (expected_expired.size() == 0) begin
        report($sformatf("result expired=%0b with nothing outstanding", got));
      end else begin
        want = expected_expired.pop_front();
        if (got !== want)
          report($sformatf("result %0d: expired=%0b, predicted %0b", n_results, got, want));
      end
    endtask

    function int pending();
      return expected_expired.size();
    endfunction
  endclass

  logic               clk;
  logic               rst;
  logic               in_valid;
  logic               in_stall;
  logic               mode;
  logic [SLOT_W-1:0]  slot;
  logic [COUNT_W-1:0] cycle_count;
  logic               out_valid;
  logic               out_stall;
  logic               expired;

  slot_table_scoreboard sb;
  int                   send_idle_pct;
  int                   recv_idle_pct;
  int                   idle_cycles;
  bit [SLOT_W-1:0]      slot_pool [8];

  polled_delay_slot_table_core dut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .mode        (mode),
    .slot        (slot),
    .cycle_count (cycle_count),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .expired     (expired)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Receiver side: stall at random, decided at the falling edge
  always @(negedge clk) begin
    out_stall <= (recv_idle_pct > 0) && (int'($urandom_range(0, 99)) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) sb.check_expired(expired);
  end

  // Watchdog: count cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("polled_delay_slot_table_core_tb: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Entered and left at a falling edge; holds the payload until the transfer.
  task automatic send_item(slot_op_e op, bit [SLOT_W-1:0] s, bit [COUNT_W-1:0] c);
    while (int'($urandom_range(0, 99)) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    mode        <= op;
    slot        <= s;
    cycle_count <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note_item(op, s, c);
    @(negedge clk);
  endtask

  task automatic run_directed();
    // slot zero: fires on first poll, then counts from all ones
    send_item(MODE_POLL,  8'd0,   16'h1234);
    send_item(MODE_POLL,  8'd0,   16'h0000);
    send_item(MODE_CLEAR, 8'd0,   16'hFFFF);
    send_item(MODE_POLL,  8'd0,   16'hFFFF);
    // top slot: zero count fires on the next poll
    send_item(MODE_POLL,  8'd255, 16'h0000);
    send_item(MODE_POLL,  8'd255, 16'hFFFF);
    send_item(MODE_POLL,  8'd255, 16'hFFFF);
    send_item(MODE_POLL,  8'd255, 16'h0000);
    send_item(MODE_CLEAR, 8'd255, 16'h0000);
    // count of one: arm, decrement, fire, then rearm over the wrapped counter
    send_item(MODE_POLL,  8'd255, 16'h0001);
    send_item(MODE_POLL,  8'd255, 16'h0000);
    send_item(MODE_POLL,  8'd255, 16'h0000);
    send_item(MODE_POLL,  8'd255, 16'h0002);
    send_item(MODE_POLL,  8'd255, 16'h0000);
    // alternating patterns on slot and count, and a clear of an untouched slot
    send_item(MODE_POLL,  8'hAA,  16'hAAAA);
    send_item(MODE_POLL,  8'h55,  16'h5555);
    send_item(MODE_CLEAR, 8'hAA,  16'h5555);
    send_item(MODE_CLEAR, 8'h81,  16'hAAAA);
    send_item(MODE_POLL,  8'h55,  16'h0000);
    send_item(MODE_CLEAR, 8'h55,  16'h0000);
    send_item(MODE_POLL,  8'hAA,  16'h0000);
    send_item(MODE_POLL,  8'hAA,  16'h0000);
  endtask

  // Mostly arm/poll runs on a small set of slots so that slots fire often;
  // the rest is clears and fully random transfers.
  task automatic run_random(int n_items);
    int              r;
    bit [SLOT_W-1:0] s;
    bit [COUNT_W-1:0] c;
    slot_pool[0] = 8'd0;
    slot_pool[1] = 8'd255;
    for (int i = 2; i < 8; i++) slot_pool[i] = SLOT_W'($urandom_range(1, 254));
    for (int i = 0; i < n_items; i++) begin
      r = int'($urandom_range(0, 99));
      s = slot_pool[$urandom_range(0, 7)];
      if ($urandom_range(0, 9) == 0) c = COUNT_W'($urandom());
      else c = COUNT_W'($urandom_range(0, 3));
      if (r < 70) begin
        send_item(MODE_POLL, s, c);
      end else if (r < 82) begin
        send_item(MODE_CLEAR, s, COUNT_W'($urandom()));
      end else begin
        send_item(slot_op_e'($urandom_range(0, 1)), SLOT_W'($urandom()), COUNT_W'($urandom()));
      end
    end
  endtask

  initial begin
    sb            = new();
    send_idle_pct = 37;
    recv_idle_pct = 52;
    idle_cycles   = 0;
    rst           = 1'b1;
    in_valid      = 1'b0;
    mode          = 1'b0;
    slot          = '0;
    cycle_count   = '0;
    out_stall     = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    run_directed();
    run_random(ITEMS_PER_PHASE);
    send_idle_pct = 52;
    recv_idle_pct = 37;
    run_random(ITEMS_PER_PHASE);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(ITEMS_PER_PHASE);
    in_valid <= 1'b0;

    // drain, then give any stray result time to show up
    while (sb.pending() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("covered %0d polls and %0d clears over three gap profiles",
             sb.n_polls, sb.n_clears);
    $display("checked %0d results, %0d of them expirations", sb.n_results, sb.n_fired);
    if (sb.errors == 0) begin
      $display("polled_delay_slot_table_core_tb: clean");
    end else begin
      $display("polled_delay_slot_table_core_tb: errors");
    end
    $finish;
  end

endmodule
